[src/sawr_pkg.sv]
// Shared types, constants and helper functions of the stop-and-wait receiver.
// No dependencies; the top level of the block imports this package.
package sawr_pkg;

   // Largest payload, in bytes, that a datagram may carry behind its header.
   localparam int MAX_PAYLOAD = 4096;

   // Header layout: checksum, length, flag and sequence, six bytes in all.
   localparam int HDR_BYTES = 6;

   // Width of the per-packet byte counter and the value at which it saturates.
   localparam int OFFSET_W = 13;
   localparam logic [OFFSET_W-1:0] OFFSET_SAT = '1;

   // Byte positions of the header fields.
   localparam logic [OFFSET_W-1:0] POS_LEN_LO = OFFSET_W'(2);
   localparam logic [OFFSET_W-1:0] POS_LEN_HI = OFFSET_W'(3);
   localparam logic [OFFSET_W-1:0] POS_FLAG   = OFFSET_W'(4);
   localparam logic [OFFSET_W-1:0] POS_SEQ    = OFFSET_W'(5);

   // Flag codes as they appear in the received flag byte.
   localparam logic [7:0] FLAG_DATA = 8'h00;
   localparam logic [7:0] FLAG_END  = 8'h07;

   // Flag codes carried by a reply.
   localparam logic [2:0] REPLY_RESEND = 3'h1;
   localparam logic [2:0] REPLY_ACK    = 3'h2;
   localparam logic [2:0] REPLY_END    = 3'h7;

   // A ones-complement sum that is all ones marks a good checksum.
   localparam logic [15:0] SUM_GOOD = 16'hffff;

   typedef enum logic [1:0] {
      VERDICT_ACK    = 2'd0,
      VERDICT_RESEND = 2'd1,
      VERDICT_END    = 2'd2
   } verdict_type;

   // 16-bit ones-complement addition with end-around carry.
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? (s[15:0] + 16'd1) : s[15:0];
   endfunction

   // Adds a length to the running byte total, saturating at all ones.
   function automatic logic [31:0] sat_add(input logic [31:0] total,
                                           input logic [15:0] len);
      logic [32:0] t;
      t = {1'b0, total} + {17'b0, len};
      return t[32] ? '1 : t[31:0];
   endfunction

endpackage

[src/sawr_req_if.sv]
// Input channel of the stop-and-wait receiver: one datagram byte per beat.
// No dependencies.
interface sawr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       last_byte;

   modport source (output valid, output rx_byte, output last_byte, input ready);
   modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

[src/sawr_rsp_if.sv]
// Reply channel of the stop-and-wait receiver: one reply header per beat.
// No dependencies.
interface sawr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  verdict;
   logic [2:0]  reply_flag;
   logic [7:0]  reply_seq;
   logic [15:0] reply_length;
   logic [15:0] reply_checksum;
   logic [31:0] delivered_total;

   modport source (output valid, output verdict, output reply_flag, output reply_seq,
                   output reply_length, output reply_checksum, output delivered_total,
                   input ready);
   modport sink   (input valid, input verdict, input reply_flag, input reply_seq,
                   input reply_length, input reply_checksum, input delivered_total,
                   output ready);
endinterface

[src/stop_and_wait_receiver_unit.sv]
// Top level of the stop-and-wait receiver: byte-serial header parse, checksum and reply.
// Depends on sawr_pkg, sawr_req_if and sawr_rsp_if.
//
//   Channel    Direction  Beat contents
//   req_chan   in         rx_byte, last_byte (one datagram byte)
//   rsp_chan   out        verdict, reply_flag, reply_seq, reply_length,
//                         reply_checksum, delivered_total (one reply)
//
// One byte is taken per cycle. A byte is captured in the input register and folded
// into the packet state when the input stage moves on; the same edge loads the result
// register with the reply to a last byte, which is then offered on rsp_chan. The rate
// is set by the single result register: the input stage moves on whenever that
// register is empty or is being read.
// Reset is synchronous and active high; it clears the packet state, the expected
// sequence number and the byte total. While a reply is stalled, one more byte is
// still taken into the input register and then the input side waits.
module stop_and_wait_receiver_unit (
   input logic       clock,
   input logic       reset,
   sawr_req_if.sink   req_chan,
   sawr_rsp_if.source rsp_chan
);
   import sawr_pkg::*;

   // Highest byte position, counted from zero, that the last byte may take.
   localparam int LAST_POS_MAX = HDR_BYTES - 1 + MAX_PAYLOAD;

   // Input register.
   logic       beat_valid_ff, beat_valid_in;
   logic [7:0] beat_byte_ff,  beat_byte_in;
   logic       beat_last_ff,  beat_last_in;

   // Per-packet state.
   logic [OFFSET_W-1:0] offset_ff,  offset_in;
   logic [15:0]         run_sum_ff, run_sum_in;
   logic [15:0]         hdr_sum_ff, hdr_sum_in;
   logic [7:0]          pending_ff, pending_in;
   logic [15:0]         length_ff,  length_in;
   logic [7:0]          flag_ff,    flag_in;
   logic [7:0]          seq_ff,     seq_in;

   // Session state.
   logic [7:0]  expected_ff, expected_in;
   logic [31:0] total_ff,    total_in;

   // Result register.
   logic        rsp_valid_ff,    rsp_valid_in;
   verdict_type rsp_verdict_ff,  rsp_verdict_in;
   logic [2:0]  rsp_flag_ff,     rsp_flag_in;
   logic [7:0]  rsp_seq_ff,      rsp_seq_in;
   logic [15:0] rsp_length_ff,   rsp_length_in;
   logic [15:0] rsp_checksum_ff, rsp_checksum_in;
   logic [31:0] rsp_total_ff,    rsp_total_in;

   logic        advance;
   logic        step;
   logic        emit;
   logic        counting;
   logic [15:0] word;
   logic [15:0] sum_all;
   logic [7:0]  seq_eff;
   logic [15:0] hdr_eff;
   logic        size_ok;
   logic [31:0] total_plus;

   // The input stage moves whenever the result register can take a new value.
   assign advance       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !beat_valid_ff || advance;
   assign step          = beat_valid_ff && advance;

   always_comb begin
      beat_valid_in = beat_valid_ff;
      beat_byte_in  = beat_byte_ff;
      beat_last_in  = beat_last_ff;
      if (req_chan.ready) begin
         beat_valid_in = req_chan.valid;
         beat_byte_in  = req_chan.rx_byte;
         beat_last_in  = req_chan.last_byte;
      end
   end

   // An odd position closes a word with the waiting low byte. An even position that
   // ends the packet counts as a word whose high byte is zero. One adder serves both.
   assign counting   = (offset_ff != OFFSET_SAT);
   assign word       = offset_ff[0] ? {beat_byte_ff, pending_ff} : {8'h00, beat_byte_ff};
   assign sum_all    = oc_add(run_sum_ff, word);
   assign seq_eff    = (offset_ff == POS_SEQ) ? beat_byte_ff : seq_ff;
   assign hdr_eff    = (offset_ff == POS_SEQ) ? sum_all : hdr_sum_ff;
   assign total_plus = sat_add(total_ff, length_ff);

   // The packet needs a full header, must stay below the counter's saturation and
   // must not exceed the largest payload.
   assign size_ok = (offset_ff >= POS_SEQ) && (offset_ff < (OFFSET_SAT - OFFSET_W'(1)))
                    && (32'(offset_ff) <= 32'(LAST_POS_MAX));

   always_comb begin
      offset_in       = offset_ff;
      run_sum_in      = run_sum_ff;
      hdr_sum_in      = hdr_sum_ff;
      pending_in      = pending_ff;
      length_in       = length_ff;
      flag_in         = flag_ff;
      seq_in          = seq_ff;
      expected_in     = expected_ff;
      total_in        = total_ff;
      emit            = 1'b0;
      rsp_verdict_in  = rsp_verdict_ff;
      rsp_flag_in     = rsp_flag_ff;
      rsp_seq_in      = rsp_seq_ff;
      rsp_length_in   = rsp_length_ff;
      rsp_total_in    = rsp_total_ff;

      if (step) begin
         if (counting) begin
            if (offset_ff[0]) begin
               run_sum_in = sum_all;
            end else begin
               pending_in = beat_byte_ff;
            end
            if (offset_ff == POS_LEN_LO) length_in[7:0]  = beat_byte_ff;
            if (offset_ff == POS_LEN_HI) length_in[15:8] = beat_byte_ff;
            if (offset_ff == POS_FLAG)   flag_in         = beat_byte_ff;
            if (offset_ff == POS_SEQ) begin
               seq_in     = beat_byte_ff;
               hdr_sum_in = sum_all;
            end
            offset_in = offset_ff + OFFSET_W'(1);
         end

         if (beat_last_ff) begin
            offset_in  = '0;
            run_sum_in = '0;
            hdr_sum_in = '0;
            pending_in = '0;
            length_in  = '0;
            flag_in    = '0;
            seq_in     = '0;

            if (size_ok) begin
               if (flag_ff == FLAG_END) begin
                  // An end packet only needs a good header; its payload is ignored.
                  if (hdr_eff == SUM_GOOD) begin
                     emit           = 1'b1;
                     rsp_verdict_in = VERDICT_END;
                     rsp_flag_in    = REPLY_END;
                     rsp_seq_in     = seq_eff;
                     rsp_length_in  = length_ff;
                     rsp_total_in   = total_ff;
                     total_in       = '0;
                     expected_in    = '0;
                  end
               end else if (flag_ff == FLAG_DATA && sum_all == SUM_GOOD) begin
                  emit          = 1'b1;
                  rsp_length_in = '0;
                  if (seq_eff != expected_ff) begin
                     rsp_verdict_in = VERDICT_RESEND;
                     rsp_flag_in    = REPLY_RESEND;
                     rsp_seq_in     = seq_eff;
                     rsp_total_in   = total_ff;
                  end else begin
                     rsp_verdict_in = VERDICT_ACK;
                     rsp_flag_in    = REPLY_ACK;
                     rsp_seq_in     = expected_ff;
                     rsp_total_in   = total_plus;
                     total_in       = total_plus;
                     expected_in    = expected_ff + 8'd1;
                  end
               end
            end
         end
      end
   end

   // The reply checksum covers the length word and the flag/sequence word.
   assign rsp_checksum_in = ~oc_add(rsp_length_in, {rsp_seq_in, 5'b0, rsp_flag_in});

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_valid_ff <= 1'b0;
         offset_ff     <= '0;
         run_sum_ff    <= '0;
         hdr_sum_ff    <= '0;
         pending_ff    <= '0;
         length_ff     <= '0;
         flag_ff       <= '0;
         seq_ff        <= '0;
         expected_ff   <= '0;
         total_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         beat_valid_ff <= beat_valid_in;
         offset_ff     <= offset_in;
         run_sum_ff    <= run_sum_in;
         hdr_sum_ff    <= hdr_sum_in;
         pending_ff    <= pending_in;
         length_ff     <= length_in;
         flag_ff       <= flag_in;
         seq_ff        <= seq_in;
         expected_ff   <= expected_in;
         total_ff      <= total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      beat_byte_ff <= beat_byte_in;
      beat_last_ff <= beat_last_in;
      if (emit) begin
         rsp_verdict_ff  <= rsp_verdict_in;
         rsp_flag_ff     <= rsp_flag_in;
         rsp_seq_ff      <= rsp_seq_in;
         rsp_length_ff   <= rsp_length_in;
         rsp_checksum_ff <= rsp_checksum_in;
         rsp_total_ff    <= rsp_total_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.verdict         = rsp_verdict_ff;
   assign rsp_chan.reply_flag      = rsp_flag_ff;
   assign rsp_chan.reply_seq       = rsp_seq_ff;
   assign rsp_chan.reply_length    = rsp_length_ff;
   assign rsp_chan.reply_checksum  = rsp_checksum_ff;
   assign rsp_chan.delivered_total = rsp_total_ff;

   // A held byte stays in the input register until the result side frees up.
   a_beat_held: assert property (@(posedge clock) disable iff (reset)
      beat_valid_ff && !advance |=> beat_valid_ff && $stable(beat_byte_ff))
      else $error("input beat lost while the result register was stalled");

   // Every processed last byte leaves the packet counter at zero.
   a_offset_clear: assert property (@(posedge clock) disable iff (reset)
      step && beat_last_ff |=> offset_ff == '0 && run_sum_ff == '0)
      else $error("packet state not cleared after the last byte");

   // An end reply restarts the session.
   a_end_restart: assert property (@(posedge clock) disable iff (reset)
      emit && rsp_verdict_in == VERDICT_END |=> expected_ff == '0 && total_ff == '0)
      else $error("session state not cleared after an end reply");

   // An acknowledgment reports the total that the block now holds.
   a_ack_total: assert property (@(posedge clock) disable iff (reset)
      emit && rsp_verdict_in == VERDICT_ACK |=> rsp_total_ff == total_ff
      && expected_ff == $past(expected_ff) + 8'd1)
      else $error("acknowledged total or sequence out of step");

   // A new reply is loaded only into a result register that is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> !rsp_valid_ff || rsp_chan.ready)
      else $error("reply overwrote one that was not yet taken");

endmodule
